/* rtl/rmv_pkg.sv */
// ----------------------------------------------------------------------------
// rmv_pkg: shared types and constants for the running mean/variance block
// Request and result layouts, the internal work word and fixed sizes.
// ----------------------------------------------------------------------------
package rmv_pkg;

  localparam int COUNT_BITS  = 20;
  localparam int SAMPLE_BITS = 16;
  localparam int MEAN_FRAC   = 16;
  localparam int MEAN_BITS   = SAMPLE_BITS + MEAN_FRAC;
  localparam int M2_BITS     = 64;
  localparam int VAR_BITS    = 38;
  localparam int SD_BITS     = 23;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [VAR_BITS-1:0]   VAR_MAX   = {VAR_BITS{1'b1}};

  typedef enum logic [0:0] {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef struct packed {
    logic                          cmd;
    logic signed [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic        [COUNT_BITS-1:0] sample_count;
    logic signed [MEAN_BITS-1:0]  mean_value;
    logic        [VAR_BITS-1:0]   variance_value;
    logic        [SD_BITS-1:0]    std_dev;
    logic                         count_saturated;
  } result_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t                         op;
    logic signed [MEAN_BITS-1:0] xf;
  } work_t;

endpackage

/* rtl/running_mean_variance.sv */
// ----------------------------------------------------------------------------
// running_mean_variance: online mean / variance / standard deviation
// Welford update in fixed point; every request returns the new statistics.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  request   | push / full        | item   (cmd, sample)
//  result    | empty / pop        | result (count, mean, variance, std_dev,
//            |                    |         count_saturated)
//
//  A push onto one or more samples runs 32 divider steps for the mean update,
//  64 for M2/(n-1), 23 square-root steps and the control states between them.
//  A clear or the first push after one skips both divisions and runs only the
//  square-root steps. The radix-2 divider is shared; a full result queue adds stalls.
//  Reset (rst, synchronous) zeroes count, mean and M2 and empties both queues.
//  The intake keeps taking requests while the engine works or a result waits, until the work queue fills.
// ----------------------------------------------------------------------------
module running_mean_variance #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rmv_pkg::item_t    item,
  output logic              empty,
  input  logic              pop,
  output rmv_pkg::result_t  result
);

  import rmv_pkg::*;

  localparam int WORK_W = $bits(work_t);
  localparam int RES_W  = $bits(result_t);

  // front -> work queue
  logic  wq_push;
  logic  wq_full;
  work_t wq_in;
  // work queue -> back
  logic  wq_pop;
  logic  wq_empty;
  logic [WORK_W-1:0] wq_out;
  // back -> result queue
  logic    rq_push;
  logic    rq_full;
  result_t rq_in;
  logic [RES_W-1:0] rq_out;

  rmv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_full (wq_full),
    .q_push (wq_push),
    .q_data (wq_in)
  );

  rmv_fifo #(
    .WIDTH (WORK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wq_push),
    .wr_data (wq_in),
    .rd_en   (wq_pop),
    .rd_data (wq_out),
    .full    (wq_full),
    .empty   (wq_empty)
  );

  rmv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (wq_empty),
    .q_data  (work_t'(wq_out)),
    .q_pop   (wq_pop),
    .r_full  (rq_full),
    .r_push  (rq_push),
    .r_data  (rq_in)
  );

  // results wait here so the engine can start the next request
  rmv_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rq_push),
    .wr_data (rq_in),
    .rd_en   (pop),
    .rd_data (rq_out),
    .full    (rq_full),
    .empty   (empty)
  );

  assign result = result_t'(rq_out);

endmodule

/* rtl/rmv_fifo.sv */
// ----------------------------------------------------------------------------
// rmv_fifo: small register queue
// First-word-fall-through queue of DEPTH entries, WIDTH bits each.
// ----------------------------------------------------------------------------
module rmv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    cnt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt == FULL_CNT);
  assign empty   = (cnt == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/rmv_front.sv */
// ----------------------------------------------------------------------------
// rmv_front: request intake
// Registers each request, decodes push/clear and scales the sample to Q16.16.
// ----------------------------------------------------------------------------
module rmv_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rmv_pkg::item_t item,
  output logic          full,
  input  logic          q_full,
  output logic          q_push,
  output rmv_pkg::work_t q_data
);

  import rmv_pkg::*;

  logic  vld;
  work_t wk;

  assign full   = vld && q_full;
  assign q_push = vld && !q_full;
  assign q_data = wk;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (push && !full) begin
      vld <= 1'b1;
    end else if (q_push) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      wk.op <= item.cmd ? OP_CLEAR : OP_PUSH;
      wk.xf <= {item.sample, {MEAN_FRAC{1'b0}}};
    end
  end

endmodule

/* rtl/rmv_back.sv */
// ----------------------------------------------------------------------------
// rmv_back: statistics engine
// Sequencer with a shared radix-2 divider, a 32x32 multiplier and a square root.
// ----------------------------------------------------------------------------
module rmv_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  rmv_pkg::work_t  q_data,
  output logic            q_pop,
  input  logic            r_full,
  output logic            r_push,
  output rmv_pkg::result_t r_data
);

  import rmv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UPDATE, S_DIVM, S_NEWMEAN, S_MUL, S_ACC,
    S_FINISH, S_DIVV, S_SATV, S_SQRT, S_DONE
  } state_t;

  localparam int RAD_BITS = VAR_BITS + 8;
  localparam int SREM_BITS = SD_BITS + 3;
  localparam int SQ_REM_BITS = SREM_BITS - 2;

  state_t                      state;
  op_t                         op;
  logic signed [MEAN_BITS-1:0] xf;
  logic        [COUNT_BITS-1:0] count;
  logic signed [MEAN_BITS-1:0] mean;
  logic        [M2_BITS-1:0]   m2;
  logic        [MEAN_BITS-1:0] dabs;
  logic        [MEAN_BITS-1:0] eabs;
  logic                        dneg;
  logic        [2*MEAN_BITS-1:0] prod;
  logic        [COUNT_BITS-1:0] dvs;
  logic        [COUNT_BITS-1:0] rem;
  logic        [M2_BITS-1:0]   dq;
  logic        [6:0]           step;
  logic        [VAR_BITS-1:0]  var_r;
  logic        [RAD_BITS-1:0]  rad;
  logic        [SQ_REM_BITS-1:0] srem;
  logic        [SD_BITS-1:0]   root;

  logic        [COUNT_BITS-1:0] cnt_inc;
  logic signed [MEAN_BITS:0]   d;
  logic        [COUNT_BITS:0]   r2;
  logic                        div_ge;
  logic signed [MEAN_BITS:0]   nm;
  logic signed [MEAN_BITS:0]   e;
  logic        [M2_BITS:0]     m2_sum;
  logic        [SREM_BITS-1:0] s2;
  logic        [SREM_BITS-1:0] trial;
  logic                        sq_ge;

  always_comb begin
    cnt_inc = (count == COUNT_MAX) ? count : count + 1'b1;
    d       = {xf[MEAN_BITS-1], xf} - {mean[MEAN_BITS-1], mean};
    r2      = {rem, dq[M2_BITS-1]};
    div_ge  = (r2 >= {1'b0, dvs});
    nm      = dneg ? ({mean[MEAN_BITS-1], mean} - {1'b0, dq[MEAN_BITS-1:0]})
                   : ({mean[MEAN_BITS-1], mean} + {1'b0, dq[MEAN_BITS-1:0]});
    e       = {xf[MEAN_BITS-1], xf} - nm;
    m2_sum  = {1'b0, m2} + {{(M2_BITS-2*MEAN_BITS+25){1'b0}}, prod[2*MEAN_BITS-1:24]};
    s2      = {srem, rad[RAD_BITS-1 -: 2]};
    trial   = {1'b0, root, 2'b01};
    sq_ge   = (s2 >= trial);
  end

  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign r_push = (state == S_DONE) && !r_full;

  always_comb begin
    r_data.sample_count    = count;
    r_data.mean_value      = mean;
    r_data.variance_value  = var_r;
    r_data.std_dev         = root;
    r_data.count_saturated = (count == COUNT_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      mean  <= '0;
      m2    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            op    <= q_data.op;
            xf    <= q_data.xf;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (op == OP_CLEAR) begin
            count <= '0;
            mean  <= '0;
            m2    <= '0;
            state <= S_FINISH;
          end else begin
            count <= cnt_inc;
            if (cnt_inc == COUNT_BITS'(1)) begin
              mean  <= xf;
              m2    <= '0;
              state <= S_FINISH;
            end else begin
              dneg  <= d[MEAN_BITS];
              dabs  <= d[MEAN_BITS] ? MEAN_BITS'(-d) : d[MEAN_BITS-1:0];
              dq    <= {(d[MEAN_BITS] ? MEAN_BITS'(-d) : d[MEAN_BITS-1:0]),
                        {(M2_BITS-MEAN_BITS){1'b0}}};
              rem   <= '0;
              dvs   <= cnt_inc;
              step  <= 7'(MEAN_BITS);
              state <= S_DIVM;
            end
          end
        end
        S_DIVM, S_DIVV: begin
          rem  <= div_ge ? COUNT_BITS'(r2 - {1'b0, dvs}) : r2[COUNT_BITS-1:0];
          dq   <= {dq[M2_BITS-2:0], div_ge};
          step <= step - 1'b1;
          if (step == 7'd1) begin
            state <= (state == S_DIVM) ? S_NEWMEAN : S_SATV;
          end
        end
        S_NEWMEAN: begin
          mean  <= nm[MEAN_BITS-1:0];
          eabs  <= e[MEAN_BITS] ? MEAN_BITS'(-e) : e[MEAN_BITS-1:0];
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= dabs * eabs;
          state <= S_ACC;
        end
        S_ACC: begin
          m2    <= m2_sum[M2_BITS] ? {M2_BITS{1'b1}} : m2_sum[M2_BITS-1:0];
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (count > COUNT_BITS'(1)) begin
            dq    <= m2;
            rem   <= '0;
            dvs   <= count - 1'b1;
            step  <= 7'(M2_BITS);
            state <= S_DIVV;
          end else begin
            var_r <= '0;
            rad   <= '0;
            srem  <= '0;
            root  <= '0;
            step  <= 7'(SD_BITS);
            state <= S_SQRT;
          end
        end
        S_SATV: begin
          var_r <= (|dq[M2_BITS-1:VAR_BITS]) ? VAR_MAX : dq[VAR_BITS-1:0];
          rad   <= {((|dq[M2_BITS-1:VAR_BITS]) ? VAR_MAX : dq[VAR_BITS-1:0]), 8'h00};
          srem  <= '0;
          root  <= '0;
          step  <= 7'(SD_BITS);
          state <= S_SQRT;
        end
        S_SQRT: begin
          srem <= sq_ge ? SQ_REM_BITS'(s2 - trial) : s2[SQ_REM_BITS-1:0];
          root <= {root[SD_BITS-2:0], sq_ge};
          rad  <= {rad[RAD_BITS-3:0], 2'b00};
          step <= step - 1'b1;
          if (step == 7'd1) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!r_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && op == OP_CLEAR) |=> (count == '0 && m2 == '0))
    else $error("clear did not zero the statistics");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && op == OP_PUSH) |=> (count != '0 && count >= $past(count)))
    else $error("push did not advance the count");

  a_var_small_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && count < COUNT_BITS'(2)) |-> (var_r == '0 && root == '0))
    else $error("variance nonzero with fewer than two samples");

  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVM || state == S_DIVV || state == S_SQRT) |-> (step != '0))
    else $error("iteration counter ran out");
`endif

endmodule
